// File: rtl/assert_macros.svh
// Assertion macros shared by the setpoint profile RTL.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BRSP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brsp assertion failed");

// Next-cycle implication, disabled during reset.
`define BRSP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brsp assertion failed");

`endif

// File: rtl/brsp_pkg.sv
// Package for the bent-ramp setpoint profile: register indexes, config struct,
// coefficient sequencer types. No dependencies.
`timescale 1ns / 1ps

package brsp_pkg;

  typedef enum logic [2:0] {
    REG_START_TEMP  = 3'd0,
    REG_END_TEMP    = 3'd1,
    REG_END_TIME    = 3'd2,
    REG_BEND_AMOUNT = 3'd3,
    REG_RAMP_TIME   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic        [8:0]  start_temp;
    logic        [8:0]  end_temp;
    logic        [15:0] end_time;
    logic signed [8:0]  bend_amount;
    logic        [15:0] ramp_time;
  } cfg_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOAD,
    CS_STEP
  } coef_state_t;

  typedef enum logic [1:0] {
    JOB_SLOPE,
    JOB_BEND_LO,
    JOB_BEND_HI
  } coef_job_t;

  localparam int PCT_MAX = 100;

endpackage

// File: rtl/brsp_coef_div.sv
// Sequential restoring divider that derives the slope and bend coefficients
// from the config registers after each write. Depends on brsp_pkg.
`timescale 1ns / 1ps

module brsp_coef_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr,
  input  brsp_pkg::cfg_t              cfg,
  output logic                        busy,
  output logic signed [FRAC_BITS+9:0] slope,
  output logic signed [FRAC_BITS+9:0] coef_lo,
  output logic signed [FRAC_BITS+9:0] coef_hi
);

  localparam int NB = FRAC_BITS + 9;   // quotient bits
  localparam int CW = NB + 1;          // signed coefficient
  localparam int CNTW = $clog2(NB);

  brsp_pkg::coef_state_t state, state_next;
  brsp_pkg::coef_job_t   job;

  logic [CNTW-1:0] cnt;
  logic [NB-1:0]   num;
  logic [NB-1:0]   quo;
  logic [15:0]     rem;
  logic [15:0]     den;
  logic            neg;
  logic            last;

  // load operands for the current job
  logic [9:0]  diff;
  logic [9:0]  bend_ext;
  logic [8:0]  mag_ld;
  logic        neg_ld;
  logic [15:0] den_ld;

  logic [16:0]   r2;
  logic          ge;
  logic [16:0]   r2_sub;
  logic [NB-1:0] quo_next;
  logic [CW-1:0] q_mag;
  logic [CW-1:0] q_fin;

  always_comb begin
    diff     = {1'b0, cfg.end_temp} - {1'b0, cfg.start_temp};
    bend_ext = {cfg.bend_amount[8], cfg.bend_amount};
    neg_ld   = 1'b0;
    mag_ld   = '0;
    den_ld   = '0;
    case (job)
      brsp_pkg::JOB_SLOPE: begin
        neg_ld = diff[9];
        mag_ld = diff[9] ? 9'(-diff) : diff[8:0];
        den_ld = cfg.end_time;
      end
      brsp_pkg::JOB_BEND_LO: begin
        neg_ld = bend_ext[9];
        mag_ld = bend_ext[9] ? 9'(-bend_ext) : bend_ext[8:0];
        den_ld = cfg.ramp_time;
      end
      default: begin
        neg_ld = bend_ext[9];
        mag_ld = bend_ext[9] ? 9'(-bend_ext) : bend_ext[8:0];
        // only used when ramp_time < end_time
        den_ld = (cfg.ramp_time < cfg.end_time) ? cfg.end_time - cfg.ramp_time : 16'd0;
      end
    endcase
  end

  always_comb begin
    r2       = {rem, num[NB-1]};
    ge       = r2 >= {1'b0, den};
    r2_sub   = r2 - {1'b0, den};
    quo_next = {quo[NB-2:0], ge};
    q_mag    = {1'b0, quo_next};
    q_fin    = (den == 16'd0) ? '0 : (neg ? -q_mag : q_mag);
    last     = (cnt == CNTW'(NB - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brsp_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      brsp_pkg::CS_IDLE: state_next = brsp_pkg::CS_IDLE;
      brsp_pkg::CS_LOAD: state_next = brsp_pkg::CS_STEP;
      brsp_pkg::CS_STEP: begin
        if (last) begin
          state_next = (job == brsp_pkg::JOB_BEND_HI) ? brsp_pkg::CS_IDLE : brsp_pkg::CS_LOAD;
        end
      end
      default: state_next = brsp_pkg::CS_IDLE;
    endcase
    if (cfg_wr) begin
      state_next = brsp_pkg::CS_LOAD;
    end
  end

  assign busy = (state != brsp_pkg::CS_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      job     <= brsp_pkg::JOB_SLOPE;
      slope   <= '0;
      coef_lo <= '0;
      coef_hi <= '0;
    end else if (cfg_wr) begin
      job <= brsp_pkg::JOB_SLOPE;
    end else if (state == brsp_pkg::CS_STEP && last) begin
      case (job)
        brsp_pkg::JOB_SLOPE:   slope   <= $signed(q_fin);
        brsp_pkg::JOB_BEND_LO: coef_lo <= $signed(q_fin);
        default:               coef_hi <= $signed(q_fin);
      endcase
      case (job)
        brsp_pkg::JOB_SLOPE:   job <= brsp_pkg::JOB_BEND_LO;
        default:               job <= brsp_pkg::JOB_BEND_HI;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == brsp_pkg::CS_LOAD) begin
      num <= {mag_ld, {FRAC_BITS{1'b0}}};
      den <= den_ld;
      neg <= neg_ld;
      rem <= '0;
      quo <= '0;
      cnt <= '0;
    end else if (state == brsp_pkg::CS_STEP) begin
      num <= {num[NB-2:0], 1'b0};
      rem <= ge ? r2_sub[15:0] : r2[15:0];
      quo <= quo_next;
      cnt <= cnt + CNTW'(1);
    end
  end

endmodule

// File: rtl/brsp_eval.sv
// Three-stage setpoint datapath: select, multiply, sum and saturate.
// Depends on brsp_pkg and coefficients from brsp_coef_div.
`timescale 1ns / 1ps

module brsp_eval #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [15:0]                 elapsed_seconds,
  input  brsp_pkg::cfg_t              cfg,
  input  logic signed [FRAC_BITS+9:0] slope,
  input  logic signed [FRAC_BITS+9:0] coef_lo,
  input  logic signed [FRAC_BITS+9:0] coef_hi,
  output logic                        out_valid,
  output logic [7:0]                  setpoint,
  output logic                        finished
);

  localparam int CW = FRAC_BITS + 10;
  localparam int PW = CW + 17;
  localparam int SW = PW + 1;

  // stage A
  logic                 va, fin_a, peak_a;
  logic [15:0]          tv_a, m_a;
  logic signed [CW-1:0] coef_a;
  // stage B
  logic                 vb, fin_b;
  logic signed [PW-1:0] ps_b, pb_b;
  // stage A inputs, stage C sum and saturation
  logic                 fin_in;
  logic [15:0]          tv_in;
  logic signed [SW-1:0] sum;
  logic [7:0]           sat;

  always_comb begin
    fin_in = elapsed_seconds >= cfg.end_time;
    tv_in  = fin_in ? cfg.end_time : elapsed_seconds;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    fin_a  <= fin_in;
    tv_a   <= tv_in;
    peak_a <= tv_in == cfg.ramp_time;
    if (tv_in < cfg.ramp_time) begin
      coef_a <= coef_lo;
      m_a    <= tv_in;
    end else begin
      coef_a <= coef_hi;
      m_a    <= cfg.end_time - tv_in;
    end
  end

  always_ff @(posedge clk) begin
    fin_b <= fin_a;
    ps_b  <= slope * $signed({1'b0, tv_a});
    if (peak_a) begin
      pb_b <= $signed({{(PW-9-FRAC_BITS){cfg.bend_amount[8]}}, cfg.bend_amount,
                       {FRAC_BITS{1'b0}}});
    end else begin
      pb_b <= coef_a * $signed({1'b0, m_a});
    end
  end

  always_comb begin
    sum = $signed({{(SW-9-FRAC_BITS){1'b0}}, cfg.start_temp, {FRAC_BITS{1'b0}}})
        + $signed({ps_b[PW-1], ps_b}) + $signed({pb_b[PW-1], pb_b});
    if (sum[SW-1]) begin
      sat = 8'd0;
    end else if (|sum[SW-2:FRAC_BITS+8]) begin
      sat = 8'hFF;
    end else begin
      sat = sum[FRAC_BITS+7:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    setpoint <= sat;
    finished <= fin_b;
  end

endmodule

// File: rtl/brsp_pct_div.sv
// Pipelined restoring divider for percent progress, one quotient bit per stage.
// Depends on brsp_pkg.
`timescale 1ns / 1ps

module brsp_pct_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [15:0] elapsed_seconds,
  input  logic [15:0] end_time,
  output logic        out_valid,
  output logic [6:0]  progress_pct
);

  localparam int F = FRAC_BITS;

  logic          v [0:F];
  logic          z [0:F];
  logic [15:0]   r [0:F];
  logic [F-1:0]  q [0:F];

  logic [F+6:0]  prod;
  logic [6:0]    praw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    r[0] <= elapsed_seconds;
    q[0] <= '0;
    z[0] <= elapsed_seconds >= end_time;
  end

  for (genvar i = 1; i <= F; i++) begin : g_step
    logic [16:0] r2;
    logic [16:0] r2_sub;
    logic        ge;
    always_comb begin
      r2     = {r[i-1], 1'b0};
      ge     = r2 >= {1'b0, end_time};
      r2_sub = r2 - {1'b0, end_time};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else begin
        v[i] <= v[i-1];
      end
    end
    always_ff @(posedge clk) begin
      r[i] <= ge ? r2_sub[15:0] : r2[15:0];
      q[i] <= {q[i-1][F-2:0], ge};
      z[i] <= z[i-1];
    end
  end

  always_comb begin
    prod = {7'd0, q[F]} * (F+7)'(brsp_pkg::PCT_MAX);
    praw = prod[F+6:F];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v[F];
    end
  end

  always_ff @(posedge clk) begin
    if (z[F]) begin
      progress_pct <= 7'd0;
    end else if (praw > 7'(brsp_pkg::PCT_MAX)) begin
      progress_pct <= 7'(brsp_pkg::PCT_MAX);
    end else begin
      progress_pct <= praw;
    end
  end

endmodule

// File: rtl/bent_ramp_setpoint_profile.sv
// Top level of the bent-ramp setpoint profile: config registers, coefficient
// unit, setpoint pipeline, progress divider. Depends on brsp_pkg, brsp_* modules.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   | Ports                                   | Flow
// ----------+-----------------------------------------+--------------------------
// request   | start, busy, elapsed_seconds            | taken when start & !busy
// result    | done, setpoint, finished, progress_pct  | done strobe, one cycle
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | write on valid & ready
//
// The setpoint result is aligned to the progress divider (one quotient bit
// per stage); a new request may enter every cycle while busy is low.
// After each config write busy stays high while the sequential coefficient
// divider recomputes slope and bend terms.
// rst is synchronous and clears all valid bits and coefficients to zero.
// The result side has no stall: done is a strobe that is always taken.

module bent_ramp_setpoint_profile #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] elapsed_seconds,
  output logic        done,
  output logic [7:0]  setpoint,
  output logic        finished,
  output logic [6:0]  progress_pct,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW  = FRAC_BITS + 10;
  localparam int DLY = FRAC_BITS - 1;   // aligns 3-stage eval with divider
  localparam int LAT = FRAC_BITS + 2;

  brsp_pkg::cfg_t cfg;

  logic                 cfg_wr;
  logic                 accept;
  logic                 coef_busy;
  logic signed [CW-1:0] slope, coef_lo, coef_hi;

  logic       ev_valid;
  logic [7:0] ev_setpoint;
  logic       ev_finished;
  logic [7:0] sp_dly  [0:DLY-1];
  logic       fin_dly [0:DLY-1];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  // hold requests off during a write and while coefficients settle
  assign busy      = coef_busy | cfg_valid;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        brsp_pkg::REG_START_TEMP:  cfg.start_temp  <= cfg_data[8:0];
        brsp_pkg::REG_END_TEMP:    cfg.end_temp    <= cfg_data[8:0];
        brsp_pkg::REG_END_TIME:    cfg.end_time    <= cfg_data;
        brsp_pkg::REG_BEND_AMOUNT: cfg.bend_amount <= $signed(cfg_data[8:0]);
        brsp_pkg::REG_RAMP_TIME:   cfg.ramp_time   <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  brsp_coef_div #(.FRAC_BITS(FRAC_BITS)) u_coef (
    .clk     (clk),
    .rst     (rst),
    .cfg_wr  (cfg_wr),
    .cfg     (cfg),
    .busy    (coef_busy),
    .slope   (slope),
    .coef_lo (coef_lo),
    .coef_hi (coef_hi)
  );

  brsp_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (accept),
    .elapsed_seconds (elapsed_seconds),
    .cfg             (cfg),
    .slope           (slope),
    .coef_lo         (coef_lo),
    .coef_hi         (coef_hi),
    .out_valid       (ev_valid),
    .setpoint        (ev_setpoint),
    .finished        (ev_finished)
  );

  brsp_pct_div #(.FRAC_BITS(FRAC_BITS)) u_pct (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (accept),
    .elapsed_seconds (elapsed_seconds),
    .end_time        (cfg.end_time),
    .out_valid       (done),
    .progress_pct    (progress_pct)
  );

  // setpoint path finishes early; delay it to meet the divider output
  always_ff @(posedge clk) begin
    sp_dly[0]  <= ev_setpoint;
    fin_dly[0] <= ev_finished;
    for (int i = 1; i < DLY; i++) begin
      sp_dly[i]  <= sp_dly[i-1];
      fin_dly[i] <= fin_dly[i-1];
    end
  end

  assign setpoint = sp_dly[DLY-1];
  assign finished = fin_dly[DLY-1];

  `BRSP_ASSERT_IMP(a_done_lat, clk, rst, done, $past(accept, LAT))
  `BRSP_ASSERT_IMP(a_eval_align, clk, rst, done, $past(ev_valid, DLY))
  `BRSP_ASSERT_IMP(a_fin_pct, clk, rst, done && finished, progress_pct == 7'd0)
  `BRSP_ASSERT_NXT(a_cfg_busy, clk, rst, cfg_wr, busy)

endmodule
